>>> rtl/core/albd_pkg.sv
// ----------------------------------------------------------------------------
// Ladder button decoder package
// Shared types, register codes and fixed sizes for the keypad decoder.
// ----------------------------------------------------------------------------
package albd_pkg;

	localparam int MAX_BUTTONS    = 6;
	localparam int ADC_FULL_SCALE = 1024;

	localparam int SAMPLE_W = 10;
	localparam int LEVEL_W  = 10;
	localparam int COUNT_W  = 3;
	localparam int DEB_W    = 16;
	localparam int HOLD_W   = 16;
	localparam int STAMP_W  = 32;
	localparam int DATA_W   = 16;
	localparam int INDEX_W  = 3;
	localparam int LVL_IDX_W = $clog2(MAX_BUTTONS);
	localparam int FS_W     = $clog2(ADC_FULL_SCALE + 1);
	localparam int SUM_W    = ((FS_W > LEVEL_W) ? FS_W : LEVEL_W) + 1;

	typedef logic signed [3:0] button_t;

	localparam button_t NO_BUTTON = -4'sd1;

	typedef enum logic [INDEX_W-1:0] {
		REG_BUTTON_COUNT,
		REG_DEBOUNCE_TIME,
		REG_LEVEL_0,
		REG_LEVEL_1,
		REG_LEVEL_2,
		REG_LEVEL_3,
		REG_LEVEL_4,
		REG_LEVEL_5
	} reg_index_t;

	typedef struct packed {
		logic              we;
		reg_index_t        index;
		logic [DATA_W-1:0] data;
	} cfg_write_t;

	typedef struct packed {
		button_t            cls;
		logic [STAMP_W-1:0] now;
		logic [HOLD_W-1:0]  hold;
	} class_item_t;

	typedef struct packed {
		button_t            current_button;
		button_t            press_button;
		button_t            release_button;
		logic [STAMP_W-1:0] press_duration;
		logic               hold_reached;
		logic               hold_crossed;
		logic               release_held;
	} result_t;

endpackage

>>> rtl/core/albd_queue.sv
// ----------------------------------------------------------------------------
// Two-entry queue
// Head and tail slots; the head always holds the oldest entry.
// ----------------------------------------------------------------------------
module albd_queue #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic             head_v_q;
	logic             tail_v_q;
	logic [WIDTH-1:0] head_q;
	logic [WIDTH-1:0] tail_q;

	assign full  = tail_v_q;
	assign empty = !head_v_q;
	assign dout  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			tail_v_q <= 1'b0;
		end else if (pop) begin
			if (tail_v_q) begin
				tail_v_q <= push;
			end else begin
				head_v_q <= push;
			end
		end else if (push) begin
			if (!head_v_q) begin
				head_v_q <= 1'b1;
			end else begin
				tail_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (tail_v_q) begin
				head_q <= tail_q;
				if (push) begin
					tail_q <= din;
				end
			end else if (push) begin
				head_q <= din;
			end
		end else if (push) begin
			if (!head_v_q) begin
				head_q <= din;
			end else begin
				tail_q <= din;
			end
		end
	end

endmodule

>>> rtl/core/albd_front.sv
// ----------------------------------------------------------------------------
// Ladder decoder front end
// Holds the ladder levels and classifies each accepted sample to a button.
// ----------------------------------------------------------------------------
module albd_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  albd_pkg::cfg_write_t     cfg,
	input  logic                     push,
	output logic                     full,
	input  logic [albd_pkg::SAMPLE_W-1:0] sample,
	input  logic [albd_pkg::STAMP_W-1:0]  now_ms,
	input  logic [albd_pkg::HOLD_W-1:0]   hold_time,
	output logic                     item_push,
	output albd_pkg::class_item_t    item,
	input  logic                     item_full
);

	import albd_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [LEVEL_W-1:0] level_q [MAX_BUTTONS];
	logic [COUNT_W-1:0] active_n;
	logic [MAX_BUTTONS-1:0] hit;
	button_t            cls;
	logic               accept;
	logic               valid_s1;
	class_item_t        item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < MAX_BUTTONS; i++) begin
				level_q[i] <= '0;
			end
		end else if (cfg.we) begin
			if (cfg.index == REG_BUTTON_COUNT) begin
				count_q <= cfg.data[COUNT_W-1:0];
			end
			for (int i = 0; i < MAX_BUTTONS; i++) begin
				if (cfg.index == reg_index_t'(REG_LEVEL_0 + INDEX_W'(i))) begin
					level_q[i] <= cfg.data[LEVEL_W-1:0];
				end
			end
		end
	end

	assign active_n = (count_q > COUNT_W'(MAX_BUTTONS)) ? COUNT_W'(MAX_BUTTONS) : count_q;

	always_comb begin
		logic [SUM_W-1:0] next_level;
		logic [SUM_W-1:0] bound;
		next_level = '0;
		bound      = '0;
		hit        = '0;
		for (int i = 0; i < MAX_BUTTONS; i++) begin
			next_level = SUM_W'(ADC_FULL_SCALE);
			if (i + 1 < MAX_BUTTONS) begin
				if (COUNT_W'(i + 1) < active_n) begin
					next_level = SUM_W'(level_q[(i + 1) % MAX_BUTTONS]);
				end
			end
			bound  = (SUM_W'(level_q[i]) + next_level) >> 1;
			hit[i] = (COUNT_W'(i) < active_n) && (SUM_W'(sample) < bound);
		end
	end

	always_comb begin
		cls = NO_BUTTON;
		for (int i = MAX_BUTTONS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				cls = button_t'(i);
			end
		end
	end

	assign full      = valid_s1 && item_full;
	assign accept    = push && !full;
	assign item_push = valid_s1 && !item_full;
	assign item      = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !item_push);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cls  <= cls;
			item_s1.now  <= now_ms;
			item_s1.hold <= hold_time;
		end
	end

endmodule

>>> rtl/core/albd_back.sv
// ----------------------------------------------------------------------------
// Ladder decoder back end
// Debounces the classified button, tracks press times and builds results.
// ----------------------------------------------------------------------------
module albd_back #(
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  albd_pkg::cfg_write_t  cfg,
	input  logic                  item_empty,
	input  albd_pkg::class_item_t item,
	output logic                  item_pop,
	output logic                  res_push,
	output albd_pkg::result_t     res,
	input  logic                  res_full
);

	import albd_pkg::*;

	logic [DEB_W-1:0]     debounce_q;
	button_t              cand_q;
	button_t              acc_q;
	logic [TIME_BITS-1:0] since_q;
	logic [TIME_BITS-1:0] press_stamp_q;
	logic [TIME_BITS-1:0] rel_stamp_q;
	logic [TIME_BITS-1:0] latest_q;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] stable_age;
	logic                 same;
	logic                 stable;
	logic                 change;
	logic [TIME_BITS-1:0] press_stamp_nx;
	logic [TIME_BITS-1:0] rel_stamp_nx;
	logic                 s2_ready;

	logic                 valid_s2;
	button_t              acc_s2;
	button_t              press_s2;
	button_t              release_s2;
	logic [TIME_BITS-1:0] now_s2;
	logic [TIME_BITS-1:0] prev_s2;
	logic [TIME_BITS-1:0] ps_s2;
	logic [TIME_BITS-1:0] rps_s2;
	logic [HOLD_W-1:0]    hold_s2;

	logic [TIME_BITS-1:0] duration;
	logic [TIME_BITS-1:0] interval;
	logic [TIME_BITS-1:0] gap;
	logic [TIME_BITS-1:0] rel_age;
	logic [TIME_BITS-1:0] hold_ext;
	logic                 reached;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= '0;
		end else if (cfg.we && cfg.index == REG_DEBOUNCE_TIME) begin
			debounce_q <= cfg.data[DEB_W-1:0];
		end
	end

	assign now_t      = item.now[TIME_BITS-1:0];
	assign same       = item.cls == cand_q;
	assign stable_age = now_t - since_q;
	assign stable     = same && (stable_age > TIME_BITS'(debounce_q));
	assign change     = stable && (item.cls != acc_q);

	assign press_stamp_nx = (change && item.cls != NO_BUTTON) ? now_t : press_stamp_q;
	assign rel_stamp_nx   = change ? press_stamp_q : rel_stamp_q;

	assign res_push = valid_s2 && !res_full;
	assign s2_ready = !valid_s2 || res_push;
	assign item_pop = !item_empty && s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q        <= NO_BUTTON;
			acc_q         <= NO_BUTTON;
			since_q       <= '0;
			press_stamp_q <= '0;
			rel_stamp_q   <= '0;
			latest_q      <= '0;
			valid_s2      <= 1'b0;
		end else begin
			if (item_pop) begin
				cand_q        <= item.cls;
				press_stamp_q <= press_stamp_nx;
				rel_stamp_q   <= rel_stamp_nx;
				latest_q      <= now_t;
				if (!same) begin
					since_q <= now_t;
				end
				if (change) begin
					acc_q <= item.cls;
				end
			end
			if (s2_ready) begin
				valid_s2 <= item_pop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			acc_s2     <= change ? item.cls : acc_q;
			press_s2   <= change ? item.cls : NO_BUTTON;
			release_s2 <= change ? acc_q : NO_BUTTON;
			now_s2     <= now_t;
			prev_s2    <= latest_q;
			ps_s2      <= press_stamp_nx;
			rps_s2     <= rel_stamp_nx;
			hold_s2    <= item.hold;
		end
	end

	assign hold_ext = TIME_BITS'(hold_s2);
	assign duration = now_s2 - ps_s2;
	assign interval = now_s2 - prev_s2;
	assign gap      = prev_s2 - ps_s2;
	assign rel_age  = now_s2 - rps_s2;
	assign reached  = duration >= hold_ext;

	always_comb begin
		res.current_button = acc_s2;
		res.press_button   = press_s2;
		res.release_button = release_s2;
		res.press_duration = '0;
		res.hold_reached   = 1'b0;
		res.hold_crossed   = 1'b0;
		res.release_held   = 1'b0;
		if (acc_s2 != NO_BUTTON) begin
			res.press_duration = STAMP_W'(duration);
			res.hold_reached   = reached;
			if (interval > duration) begin
				res.hold_crossed = reached;
			end else begin
				res.hold_crossed = reached && (gap < hold_ext);
			end
		end
		if (release_s2 != NO_BUTTON) begin
			res.release_held = rel_age >= hold_ext;
		end
	end

endmodule

>>> rtl/core/analog_ladder_button_decoder_unit.sv
// ----------------------------------------------------------------------------
// Analog ladder button decoder
// Resistor-ladder keypad decoder with debounce, press events and hold flags.
// ----------------------------------------------------------------------------
// Each input transfer carries one ADC sample, a millisecond timestamp and a
// hold time. Write push while full is low; each transfer yields exactly one
// result. Results wait in a two-entry output queue: while empty is low the
// oldest result is on the result ports, and pop with empty low takes it.
// One item per cycle is sustained while results are popped: the front
// classifies each sample against the ladder boundaries and registers it; the
// back updates debounce and press state, registers the item, then derives
// durations and hold flags. A two-entry queue sits between front and back.
// If results are not popped, the output queue and then the inner queue fill,
// and full rises. Configuration is written via write_enable, reg_index and
// write_data; the user must do so only while the block is idle, which the
// block does not enforce. Reset clears all configuration to zero, empties
// both queues and returns the decoder to no candidate and no pressed button.
// ----------------------------------------------------------------------------
module analog_ladder_button_decoder_unit #(
	parameter int TIME_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           write_enable,
	input  logic [albd_pkg::INDEX_W-1:0]   reg_index,
	input  logic [albd_pkg::DATA_W-1:0]    write_data,
	input  logic                           push,
	output logic                           full,
	input  logic [albd_pkg::SAMPLE_W-1:0]  sample,
	input  logic [albd_pkg::STAMP_W-1:0]   now_ms,
	input  logic [albd_pkg::HOLD_W-1:0]    hold_time,
	output logic                           empty,
	input  logic                           pop,
	output logic signed [3:0]              current_button,
	output logic signed [3:0]              press_button,
	output logic signed [3:0]              release_button,
	output logic [albd_pkg::STAMP_W-1:0]   press_duration,
	output logic                           hold_reached,
	output logic                           hold_crossed,
	output logic                           release_held
);

	import albd_pkg::*;

	localparam int ITEM_W = $bits(class_item_t);
	localparam int RES_W  = $bits(result_t);

	cfg_write_t       cfg;
	logic             mid_push;
	logic             mid_full;
	logic             mid_pop;
	logic             mid_empty;
	class_item_t      mid_in;
	logic [ITEM_W-1:0] mid_out;
	logic             res_push;
	logic             res_full;
	result_t          res_in;
	logic [RES_W-1:0] res_out;
	result_t          res_head;

	assign cfg.we    = write_enable;
	assign cfg.index = reg_index_t'(reg_index);
	assign cfg.data  = write_data;

	albd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.now_ms    (now_ms),
		.hold_time (hold_time),
		.item_push (mid_push),
		.item      (mid_in),
		.item_full (mid_full)
	);

	albd_queue #(
		.WIDTH (ITEM_W)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.din    (mid_in),
		.full   (mid_full),
		.pop    (mid_pop),
		.dout   (mid_out),
		.empty  (mid_empty)
	);

	albd_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_empty (mid_empty),
		.item       (class_item_t'(mid_out)),
		.item_pop   (mid_pop),
		.res_push   (res_push),
		.res        (res_in),
		.res_full   (res_full)
	);

	albd_queue #(
		.WIDTH (RES_W)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop && !empty),
		.dout   (res_out),
		.empty  (empty)
	);

	assign res_head       = result_t'(res_out);
	assign current_button = res_head.current_button;
	assign press_button   = res_head.press_button;
	assign release_button = res_head.release_button;
	assign press_duration = res_head.press_duration;
	assign hold_reached   = res_head.hold_reached;
	assign hold_crossed   = res_head.hold_crossed;
	assign release_held   = res_head.release_held;

endmodule
